// File: design/slls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slls_pkg: shared types and defaults for the strict LIS length stream
// Default sizes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package slls_pkg;

  localparam int MAX_LEN_DEF     = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for an input word
    ST_SRCH,  // first table read of the search
    ST_LOOK,  // compare read data, narrow window, issue next read
    ST_UPD,   // overwrite or append the tail entry
    ST_DONE   // hand the result to the output register
  } state_t;

endpackage

`default_nettype wire

// File: design/strict_lis_length_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strict_lis_length_stream_top: streaming longest strict monotone run length
// Patience-sort tail table with a binary search run by a small sequencer.
// ----------------------------------------------------------------------------
// Input (in_valid/in_ready, value, first): one element per word; first=1
//   empties the tail table before the element is used.
// Output (out_valid/out_ready, run_length, best_length, overflow): one word
//   per input word, in order.
// Config (cfg_valid/cfg_ready, cfg_data): direction, 0 strictly increasing,
//   1 strictly decreasing. Always ready; write it only while idle.
// Timing: with n table entries before the word (0 after a first mark) the
//   search takes k <= ceil(log2(n+1)) steps, one per cycle through the single
//   compare unit and the one-read-port tail memory. After the accept the
//   sequencer runs first read, k steps, update and output load, in that order,
//   before out_valid rises. in_ready is high only when idle, so a new word is
//   taken only once the previous one has been handed to the output register.
// Reset: rst empties the table and clears direction; memory is not cleared.
// Stall: a result waits in the output register; the next word is searched
//   meanwhile and holds in ST_DONE until the slot frees.
// ----------------------------------------------------------------------------
module strict_lis_length_stream_top #(
  parameter int MAX_LEN     = slls_pkg::MAX_LEN_DEF,
  parameter int VALUE_WIDTH = slls_pkg::VALUE_WIDTH_DEF,
  localparam int CW = $clog2(MAX_LEN + 1),
  localparam int AW = $clog2(MAX_LEN)
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          first,
  // output words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [CW-1:0]          run_length,
  output logic        [CW-1:0]          best_length,
  output logic                          overflow
);

  import slls_pkg::*;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // tail memory, one write and one registered read port
  logic signed [VALUE_WIDTH-1:0] mem [MAX_LEN];
  logic signed [VALUE_WIDTH-1:0] rdata;

  state_t state, state_next;

  logic                          direction;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 lo, hi;
  logic signed [VALUE_WIDTH-1:0] val;
  logic [CW-1:0]                 run;
  logic                          ovf;

  logic [CW-1:0]  mid, mid_nx, lo_next, hi_next;
  logic           prec;
  logic           rd_en, wr_en, load_out;
  logic [AW-1:0]  rd_addr, wr_addr;

  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] l, input logic [CW-1:0] h);
    logic [CW-1:0] d;
    d = h - l;
    return l + (d >> 1);
  endfunction

  assign cfg_ready = 1'b1;

  // shared compare unit: entry must stay before the new value
  assign mid    = mid_of(lo, hi);
  assign mid_nx = mid_of(lo_next, hi_next);
  assign prec   = direction ? (rdata > val) : (rdata < val);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (prec) begin
      lo_next = mid + ONE;
    end else begin
      hi_next = mid;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SRCH;
      ST_SRCH: state_next = (lo < hi) ? ST_LOOK : ST_UPD;
      ST_LOOK: state_next = (lo_next < hi_next) ? ST_LOOK : ST_UPD;
      ST_UPD:  state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = mid[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = (lo < count) ? lo[AW-1:0] : count[AW-1:0];
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SRCH: rd_en = (lo < hi);
      ST_LOOK: begin
        rd_en   = (lo_next < hi_next);
        rd_addr = mid_nx[AW-1:0];
      end
      ST_UPD:  wr_en = (lo < count) || (count < MAX_CNT);
      ST_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      count     <= '0;
      lo        <= '0;
      hi        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        direction <= cfg_data;
      end
      if (state == ST_IDLE && in_valid) begin
        lo <= '0;
        if (first) begin
          count <= '0;
          hi    <= '0;
        end else begin
          hi    <= count;
        end
      end
      if (state == ST_LOOK) begin
        lo <= lo_next;
        hi <= hi_next;
      end
      if (state == ST_UPD && !(lo < count) && count < MAX_CNT) begin
        count <= count + ONE;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      val <= value;
    end
    if (state == ST_UPD) begin
      if (lo < count) begin
        run <= lo + ONE;
        ovf <= 1'b0;
      end else if (count < MAX_CNT) begin
        run <= count + ONE;
        ovf <= 1'b0;
      end else begin
        run <= MAX_CNT;
        ovf <= 1'b1;
      end
    end
    if (load_out) begin
      run_length  <= run;
      best_length <= count;
      overflow    <= ovf;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("table count above MAX_LEN");

  a_look_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK |-> lo < hi)
    else $error("search step with empty window");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SRCH)
    else $error("accepted word did not start a search");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> run_length == MAX_CNT && best_length == MAX_CNT)
    else $error("overflow without a full table");

  a_run_le_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length <= best_length && run_length != '0)
    else $error("run length outside 1..best length");

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: strict LIS length stream checker
// Drives sequences of signed values, predicts run, best and overflow for each
// word from a local patience table, and compares every output word in order.
// ----------------------------------------------------------------------------
module testbench;
  import slls_pkg::*;

  localparam int MAX_LEN    = slls_pkg::MAX_LEN_DEF;
  localparam int VW         = slls_pkg::VALUE_WIDTH_DEF;
  localparam int CW         = $clog2(MAX_LEN + 1);
  localparam int MAX_GAP    = 19;     // longest idle draw per word, either side
  localparam int IDLE_LIMIT = 4000;   // cycles with no handshake before giving up
  localparam int TAIL_WAIT  = 40;     // settle time after the last result

  // direction register codes
  localparam bit DIR_UP   = 1'b0;
  localparam bit DIR_DOWN = 1'b1;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  typedef struct {
    logic signed [VW-1:0] val;
    logic                 first;
  } seq_word_t;

  typedef struct packed {
    logic [CW-1:0] run;
    logic [CW-1:0] best;
    logic          ovf;
  } lis_result_t;

  // DUT ports; every input starts at a known value
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data  = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [VW-1:0] value     = '0;
  logic                 first     = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CW-1:0]        run_length;
  logic [CW-1:0]        best_length;
  logic                 overflow;

  // Shadow of the block's state: tail table, its fill count and direction.
  logic signed [VW-1:0] tail_tbl [0:MAX_LEN-1];
  int unsigned          tail_count = 0;
  bit                   run_dir    = DIR_UP;

  seq_word_t   words_to_send [$];   // filled by the sequencer, drained by the driver
  lis_result_t results_due   [$];   // predicted output words, oldest first

  int        words_queued = 0;
  int        mismatches   = 0;
  int        idle_cycles  = 0;
  int        send_gap     = 0;
  bit        send_burst   = 1'b0;
  int        recv_stall   = 0;
  bit        recv_burst   = 1'b0;
  seq_word_t drv_word;
  lis_result_t want;

  strict_lis_length_stream_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .first       (first),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .run_length  (run_length),
    .best_length (best_length),
    .overflow    (overflow)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: binary search for the first tail the value does not strictly
  // follow, then overwrite it, append, or flag overflow when the table is full.
  // --------------------------------------------------------------------------
  function automatic lis_result_t lis_predict(input logic signed [VW-1:0] v,
                                              input logic clr);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          keep_before;
    lis_result_t r;
    if (clr) tail_count = 0;
    lo = 0;
    hi = tail_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      keep_before = (run_dir == DIR_DOWN) ? (tail_tbl[mid] > v) : (tail_tbl[mid] < v);
      if (keep_before) lo = mid + 1;
      else hi = mid;
    end
    r.ovf = 1'b0;
    if (lo < tail_count) begin
      // equal or better tail replaces an existing entry
      tail_tbl[lo] = v;
      r.run = CW'(lo + 1);
    end else if (tail_count < MAX_LEN) begin
      tail_tbl[tail_count] = v;
      tail_count++;
      r.run = CW'(tail_count);
    end else begin
      // full table: append dropped, table untouched
      r.run = CW'(MAX_LEN);
      r.ovf = 1'b1;
    end
    r.best = CW'(tail_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Once a word is up it holds until in_ready; each word is
  // preceded by a random idle gap, or none while in burst mode.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) results_due = {results_due, lis_predict(value, first)};
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          drv_word = words_to_send.pop_front();
          value    <= drv_word.val;
          first    <= drv_word.first;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each accepted word against the oldest prediction,
  // then stalls out_ready for a random count before taking the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: output word with nothing expected: run %0d best %0d ovf %0b",
                     $realtime, run_length, best_length, overflow);
        end else begin
          want = results_due.pop_front();
          if (run_length !== want.run || best_length !== want.best ||
              overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch run %0d/%0d best %0d/%0d ovf %0b/%0b (exp/got)",
                       $realtime, want.run, run_length, want.best, best_length,
                       want.ovf, overflow);
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_word(input logic signed [VW-1:0] v, input logic f);
    seq_word_t w;
    w.val   = v;
    w.first = f;
    words_to_send = {words_to_send, w};
    words_queued++;
  endtask

  // Hold the sender until every queued word is out and every result is back.
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // Direction write; only issued with the block idle.
  task automatic write_direction(input bit d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    run_dir = d;
    cfg_valid <= 1'b0;
  endtask

  // One sequence with random content. Most are well formed (first mark on the
  // lead word); the shape varies: trending runs, narrow ranges full of ties,
  // full-width values, extremes, and a noisy mix with stray first marks.
  task automatic add_sequence(input bit lead_first, input bit d);
    int                   style;
    int                   len;
    int                   i;
    int                   base;
    int                   step;
    logic signed [VW-1:0] v;
    logic                 f;
    style = $urandom_range(0, 9);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
    base  = int'($urandom_range(0, 32'h7fff_ffff)) - 32'h4000_0000;
    for (i = 0; i < len; i++) begin
      f = (i == 0) ? lead_first : 1'b0;
      case (style)
        0, 1, 2: begin
          // mostly along the counted direction, with some steps back
          step = int'($urandom_range(0, 1000)) - 150;
          base = (d == DIR_DOWN) ? base - step : base + step;
          v = base;
        end
        3, 4: v = int'($urandom_range(0, 16)) - 8;
        5, 6: v = $urandom;
        7: begin
          case ($urandom_range(0, 5))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = 0;
            3: v = -1;
            4: v = 1;
            default: v = $urandom;
          endcase
        end
        default: begin
          v = ($urandom_range(0, 1) == 0) ? $urandom : int'($urandom_range(0, 6)) - 3;
          if (i != 0) f = ($urandom_range(0, 7) == 0);
        end
      endcase
      add_word(v, f);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencer: reset, directed words, full-table run, then random phases with
  // a direction write between each.
  // --------------------------------------------------------------------------
  initial begin
    int                   p;
    int                   i;
    int                   phase_start;
    longint               acc;
    logic signed [VW-1:0] mid_val;
    bit                   d;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Increasing, starting with no first mark after reset.
    write_direction(DIR_UP);
    add_word(-5, 1'b0);
    add_word(3, 1'b0);
    add_word(3, 1'b0);          // tie overwrites, never extends
    add_word(10, 1'b0);
    add_word(VAL_MIN, 1'b0);
    add_word(VAL_MAX, 1'b0);
    add_word(VAL_MAX, 1'b0);
    add_word(-1, 1'b0);
    add_word(0, 1'b0);
    add_word(1, 1'b0);
    add_word(5, 1'b1);          // restart
    add_word(4, 1'b0);
    add_word(3, 1'b0);
    drain();

    // Flip to decreasing on the table as it stands, then restart.
    write_direction(DIR_DOWN);
    add_word(100, 1'b0);
    add_word(-100, 1'b0);
    add_word(VAL_MIN, 1'b0);
    add_word(VAL_MIN, 1'b0);
    add_word(VAL_MAX, 1'b0);
    add_word(9, 1'b1);
    add_word(8, 1'b0);
    add_word(8, 1'b0);
    add_word(7, 1'b0);
    add_word(10, 1'b0);
    drain();

    // Fill the table with a strictly increasing run, then push past the end.
    write_direction(DIR_UP);
    acc     = -64'sd2147483648;
    mid_val = '0;
    for (i = 0; i < MAX_LEN + 2; i++) begin
      acc += $urandom_range(1, 1 << 20);
      if (i == MAX_LEN / 2) mid_val = acc[VW-1:0];
      add_word(acc[VW-1:0], i == 0);
    end
    add_word(mid_val, 1'b0);    // tie in the middle of a full table
    add_word(VAL_MAX, 1'b0);    // overflow again at the top
    drain();

    // Random phases, alternating direction; a phase may carry the old table.
    for (p = 0; p < 6; p++) begin
      d = (p == 5) ? bit'($urandom_range(0, 1)) : bit'(p % 2);
      write_direction(d);
      phase_start = words_queued;
      add_sequence(bit'($urandom_range(0, 1)), d);
      while (words_queued - phase_start < 20)
        add_sequence(($urandom_range(0, 7) != 0), d);
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
